// ----- rtl/core/ffra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

   localparam int ADDR_W       = 32;
   localparam int ALIGN_W      = 17;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int MOD_CNT_W    = 5;
   localparam int MAX_BLOCKS_D = 64;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_END   = 1'b1;

   localparam logic [ADDR_W-1:0] REGION_START_RST = 32'd4096;
   localparam logic [ADDR_W-1:0] REGION_END_RST   = 32'd1048576;

   typedef struct packed {
      logic               req_type;
      logic [ADDR_W-1:0]  block_size;
      logic [ALIGN_W-1:0] alignment;
      logic [ADDR_W-1:0]  free_address;
   } alloc_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   block_address;
      logic [STATUS_W-1:0] status;
   } alloc_rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LAST_WAIT,
      S_PL_INIT,
      S_PL_MOD,
      S_PL_PAD,
      S_PL_FIT,
      S_PL_FAIL,
      S_GAP_FIRST,
      S_GAP_WAIT,
      S_POS_WAIT,
      S_INS,
      S_UP_RD,
      S_UP_WR,
      S_FR_WAIT,
      S_DN_RD,
      S_DN_WR,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/first_fit_region_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Region allocator: allocate and free blocks inside one address region.
// req_*  : request transactions (allocate or free), valid/ready.
// rsp_*  : one response transaction per request: granted address and status.
// csr_*  : register writes, index 0 region_start (also reloads the free
//          pointer), index 1 region_end. Always ready; write only when idle.
// The live-block table sits in one single-port-read, single-port-write RAM
// (registered read) of MAX_BLOCKS entries, kept sorted by start.
// Work is done by walks over that RAM and by a bit-serial remainder unit:
//   a placement attempt finds the base, its remainder by the alignment (only
//   when alignment is above one), the padding and the fit; a failed attempt
//   moves to the next gap, which takes a RAM read;
//   allocate = last-block read if the table is not empty, attempts,
//              position scan, shift up, response; free = scan, shift down, response.
// One request is worked at a time; a new request is taken as soon as the
// engine is idle, even while the previous response waits on rsp_ready.
// A stalled response holds its register; the engine then waits before
// loading the next one.
// Reset: synchronous, clears table count, loads region_end with its default
// and the free pointer with the region_start default. RAM is not cleared.
module first_fit_region_allocator
   import ffra_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_D
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  alloc_req_type        req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output alloc_rsp_type        rsp_payload,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [ADDR_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

   // table RAM
   entry_type mem [MAX_BLOCKS];
   entry_type rd_data_ff;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   entry_type        wr_data;

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] fsp_ff, fsp_in;
   logic [ADDR_W-1:0] rend_ff;
   logic              rsp_valid_ff;
   logic              rsp_load;

   // request and working registers
   logic               op_ff, op_in;
   logic [ADDR_W-1:0]  size_ff, size_in;
   logic [ALIGN_W-1:0] align_ff, align_in;
   logic [ADDR_W-1:0]  faddr_ff, faddr_in;
   logic               bumped_ff, bumped_in;
   logic [CNT_W-1:0]   gi_ff, gi_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   entry_type          cur_ff, cur_in;
   logic [ADDR_W-1:0]  p_first_ff, p_first_in;
   logic [ADDR_W-1:0]  p_skip_ff, p_skip_in;
   logic [ADDR_W-1:0]  p_limit_ff, p_limit_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  dvd_ff, dvd_in;
   logic [ALIGN_W-1:0] r_ff, r_in;
   logic [MOD_CNT_W-1:0] mcnt_ff, mcnt_in;
   logic [ALIGN_W-1:0] pad_ff, pad_in;
   logic [ADDR_W-1:0]  rem2_ff, rem2_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   alloc_rsp_type      rsp_data_ff;

   // helpers
   logic [CNT_W:0]     j_p1, j_p2, gi_p2, cnt_w;
   logic [ALIGN_W:0]   mod_t;
   logic [ALIGN_W-1:0] align_eff;
   logic [ADDR_W:0]    lim_m_first;
   logic [ADDR_W:0]    rem_fit;
   entry_type          new_entry;

   assign j_p1      = {1'b0, j_ff} + 1'b1;
   assign j_p2      = {1'b0, j_ff} + 2'd2;
   assign gi_p2     = {1'b0, gi_ff} + 2'd2;
   assign cnt_w     = {1'b0, count_ff};
   assign mod_t     = {r_ff, dvd_ff[ADDR_W-1]};
   assign align_eff = (req_payload.alignment == '0) ? ALIGN_W'(1) : req_payload.alignment;
   assign lim_m_first = {1'b0, p_limit_ff} - {1'b0, p_first_ff};
   assign rem_fit   = {1'b0, rem2_ff} - {{(ADDR_W-ALIGN_W+1){1'b0}}, pad_ff};
   assign new_entry = '{start: addr_ff, size: size_ff};

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // RAM: registered read, one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         fsp_ff       <= REGION_START_RST;
         rend_ff      <= REGION_END_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         fsp_ff   <= fsp_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REGION_START: begin
               end
               CSR_REGION_END: begin
                  rend_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      size_ff     <= size_in;
      align_ff    <= align_in;
      faddr_ff    <= faddr_in;
      bumped_ff   <= bumped_in;
      gi_ff       <= gi_in;
      j_ff        <= j_in;
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      p_first_ff  <= p_first_in;
      p_skip_ff   <= p_skip_in;
      p_limit_ff  <= p_limit_in;
      base_ff     <= base_in;
      dvd_ff      <= dvd_in;
      r_ff        <= r_in;
      mcnt_ff     <= mcnt_in;
      pad_ff      <= pad_in;
      rem2_ff     <= rem2_in;
      addr_ff     <= addr_in;
      res_st_ff   <= res_st_in;
      res_addr_ff <= res_addr_in;
      if (rsp_load) begin
         rsp_data_ff <= '{block_address: res_addr_ff, status: res_st_ff};
      end
   end

   // sequencer
   always_comb begin
      logic [ADDR_W-1:0] last_end;
      last_end    = rd_data_ff.start + rd_data_ff.size;
      state_in    = state_ff;
      count_in    = count_ff;
      fsp_in      = fsp_ff;
      op_in       = op_ff;
      size_in     = size_ff;
      align_in    = align_ff;
      faddr_in    = faddr_ff;
      bumped_in   = bumped_ff;
      gi_in       = gi_ff;
      j_in        = j_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      p_first_in  = p_first_ff;
      p_skip_in   = p_skip_ff;
      p_limit_in  = p_limit_ff;
      base_in     = base_ff;
      dvd_in      = dvd_ff;
      r_in        = r_ff;
      mcnt_in     = mcnt_ff;
      pad_in      = pad_ff;
      rem2_in     = rem2_ff;
      addr_in     = addr_ff;
      res_st_in   = res_st_ff;
      res_addr_in = res_addr_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = new_entry;
      rsp_load    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_payload.req_type;
               size_in     = req_payload.block_size;
               align_in    = align_eff;
               faddr_in    = req_payload.free_address;
               res_addr_in = '0;
               j_in        = '0;
               bumped_in   = 1'b1;
               p_skip_in   = '0;
               p_limit_in  = rend_ff;
               p_first_in  = fsp_ff;
               if (req_payload.req_type == REQ_FREE) begin
                  if (count_ff == '0) begin
                     res_st_in = ST_NOTFOUND;
                     state_in  = S_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_FR_WAIT;
                  end
               end else if (count_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = IDX_W'(count_ff - 1'b1);
                  state_in = S_LAST_WAIT;
               end else begin
                  state_in = S_PL_INIT;
               end
            end
         end
         // pointer follows the highest block
         S_LAST_WAIT: begin
            fsp_in     = last_end;
            p_first_in = last_end;
            state_in   = S_PL_INIT;
         end
         S_PL_INIT: begin
            base_in = p_first_ff + p_skip_ff;
            dvd_in  = p_first_ff + p_skip_ff;
            r_in    = '0;
            mcnt_in = '0;
            if (lim_m_first[ADDR_W] || ({1'b0, p_skip_ff} > lim_m_first)) begin
               state_in = S_PL_FAIL;
            end else if (align_ff == ALIGN_W'(1)) begin
               state_in = S_PL_PAD;
            end else begin
               state_in = S_PL_MOD;
            end
         end
         // restoring remainder, one dividend bit a cycle
         S_PL_MOD: begin
            dvd_in  = {dvd_ff[ADDR_W-2:0], 1'b0};
            mcnt_in = mcnt_ff + 1'b1;
            if (mod_t >= {1'b0, align_ff}) begin
               r_in = ALIGN_W'(mod_t - {1'b0, align_ff});
            end else begin
               r_in = mod_t[ALIGN_W-1:0];
            end
            if (mcnt_ff == MOD_CNT_W'(ADDR_W - 1)) begin
               state_in = S_PL_PAD;
            end
         end
         S_PL_PAD: begin
            pad_in   = (r_ff != '0) ? (align_ff - r_ff) : '0;
            rem2_in  = p_limit_ff - base_ff;
            state_in = S_PL_FIT;
         end
         S_PL_FIT: begin
            addr_in = base_ff + {{(ADDR_W-ALIGN_W){1'b0}}, pad_ff};
            if (!rem_fit[ADDR_W] && ({1'b0, size_ff} <= rem_fit)) begin
               j_in = '0;
               if (count_ff == '0) begin
                  pos_in   = '0;
                  state_in = S_INS;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_POS_WAIT;
               end
            end else begin
               state_in = S_PL_FAIL;
            end
         end
         S_PL_FAIL: begin
            if (bumped_ff) begin
               bumped_in = 1'b0;
               if (count_ff >= CNT_W'(2)) begin
                  rd_en    = 1'b1;
                  state_in = S_GAP_FIRST;
               end else begin
                  res_st_in = ST_NOSPACE;
                  state_in  = S_RESP;
               end
            end else begin
               gi_in  = gi_ff + 1'b1;
               cur_in = '{start: p_limit_ff, size: rd_data_ff.size};
               if (gi_p2 < cnt_w) begin
                  rd_en    = 1'b1;
                  rd_addr  = gi_p2[IDX_W-1:0];
                  state_in = S_GAP_WAIT;
               end else begin
                  res_st_in = ST_NOSPACE;
                  state_in  = S_RESP;
               end
            end
         end
         S_GAP_FIRST: begin
            cur_in   = rd_data_ff;
            gi_in    = '0;
            rd_en    = 1'b1;
            rd_addr  = IDX_W'(1);
            state_in = S_GAP_WAIT;
         end
         // rd_data_ff holds entry gi+1 until the attempt ends
         S_GAP_WAIT: begin
            p_first_in = cur_ff.start;
            p_skip_in  = cur_ff.size;
            p_limit_in = rd_data_ff.start;
            state_in   = S_PL_INIT;
         end
         S_POS_WAIT: begin
            if (rd_data_ff.start >= addr_ff) begin
               if (rd_data_ff.start == addr_ff) begin
                  wr_en       = 1'b1;
                  wr_addr     = j_ff[IDX_W-1:0];
                  res_st_in   = ST_OK;
                  res_addr_in = addr_ff;
                  if (bumped_ff) begin
                     fsp_in = addr_ff + size_ff;
                  end
                  state_in = S_RESP;
               end else begin
                  pos_in   = j_ff;
                  state_in = S_INS;
               end
            end else begin
               j_in = j_p1[CNT_W-1:0];
               if (j_p1 == cnt_w) begin
                  pos_in   = count_ff;
                  state_in = S_INS;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = j_p1[IDX_W-1:0];
               end
            end
         end
         S_INS: begin
            if (count_ff == MAX_CNT) begin
               res_st_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               j_in     = count_ff;
               state_in = S_UP_RD;
            end
         end
         S_UP_RD: begin
            if (j_ff == pos_ff) begin
               wr_en       = 1'b1;
               wr_addr     = pos_ff[IDX_W-1:0];
               count_in    = count_ff + 1'b1;
               res_st_in   = ST_OK;
               res_addr_in = addr_ff;
               if (bumped_ff) begin
                  fsp_in = addr_ff + size_ff;
               end
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(j_ff - 1'b1);
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
            j_in    = j_ff - 1'b1;
            if ((j_ff - 1'b1) > pos_ff) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(j_ff - 2'd2);
            end else begin
               state_in = S_UP_RD;
            end
         end
         S_FR_WAIT: begin
            if (rd_data_ff.start == faddr_ff) begin
               state_in = S_DN_RD;
            end else begin
               j_in = j_p1[CNT_W-1:0];
               if (j_p1 == cnt_w) begin
                  res_st_in = ST_NOTFOUND;
                  state_in  = S_RESP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = j_p1[IDX_W-1:0];
               end
            end
         end
         S_DN_RD: begin
            if (j_p1 < cnt_w) begin
               rd_en    = 1'b1;
               rd_addr  = j_p1[IDX_W-1:0];
               state_in = S_DN_WR;
            end else begin
               count_in  = count_ff - 1'b1;
               res_st_in = ST_OK;
               state_in  = S_RESP;
            end
         end
         S_DN_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
            j_in    = j_p1[CNT_W-1:0];
            if (j_p2 < cnt_w) begin
               rd_en   = 1'b1;
               rd_addr = j_p2[IDX_W-1:0];
            end else begin
               state_in = S_DN_RD;
            end
         end
         // hold until the output register is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // region_start write reloads the free pointer
      if (csr_valid && csr_ready && (csr_index == CSR_REGION_START)) begin
         fsp_in = csr_wdata;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("table count beyond capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en && (wr_addr == rd_addr)))
      else $error("RAM read and write to the same entry");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
         (count_ff == $past(count_ff) + 1'b1) || (count_ff + 1'b1 == $past(count_ff)))
      else $error("table count moved by more than one");

   a_rsp_from_engine: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready))
      else $error("response overwrote a pending transaction");

   a_count_fixed_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("table count changed while idle");
`endif

endmodule

`default_nettype wire
